// ----- rtl/slcfr_pkg.sv -----
package slcfr_pkg;

    typedef enum logic [1:0] {
        PH_SYNC1 = 2'd0,
        PH_SYNC2 = 2'd1,
        PH_LEN   = 2'd2,
        PH_DATA  = 2'd3
    } phase_t;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_SYNC_FIRST    = 2'd0,
        REG_SYNC_SECOND   = 2'd1,
        REG_TIMEOUT_TICKS = 2'd2,
        REG_MAX_LENGTH    = 2'd3
    } cfg_reg_t;

    localparam logic        KIND_BYTE   = 1'b0;
    localparam logic [15:0] CRC_POLY    = 16'h8408;
    localparam logic [15:0] CRC_INIT    = 16'hFFFF;
    localparam logic [15:0] ELAPSED_MAX = 16'hFFFF;
    localparam logic [7:0]  MIN_LENGTH  = 8'd3;

    localparam logic [7:0]  RST_SYNC_FIRST    = 8'hAA;
    localparam logic [7:0]  RST_SYNC_SECOND   = 8'h55;
    localparam logic [15:0] RST_TIMEOUT_TICKS = 16'd100;
    localparam logic [7:0]  RST_MAX_LENGTH    = 8'hFF;

    // reflected crc-16, one byte, lsb first
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                               input logic [7:0] data_in);
        logic [15:0] c;
        logic        fb;
        c = crc_in;
        for (int k = 0; k < 8; k++) begin
            fb = c[0] ^ data_in[k];
            c  = {1'b0, c[15:1]};
            if (fb) begin
                c = c ^ CRC_POLY;
            end
        end
        return c;
    endfunction

endpackage

// ----- rtl/sync_length_crc_frame_receiver_core.sv -----
// channel   direction  handshake            payload
// s_        in         s_valid / s_ready    s_kind, s_byte_value
// m_        out        m_valid / m_ready    m_frame_byte, m_byte_index, m_last, m_crc_ok
// cfg_      in         cfg_valid / cfg_ready cfg_index, cfg_data
//
// one item per cycle while the output is not stalled: an input register, then crc
// update, timeout compare and frame tracking in one pass into the output register.
// aresetn is synchronous and active low; it restores register defaults and hunt.
// a stalled output holds the input register; s_ready stays high while the
// output register is empty or being taken. cfg_ready is always high.
module sync_length_crc_frame_receiver_core (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic                               s_kind,
    input  logic [7:0]                         s_byte_value,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [7:0]                         m_frame_byte,
    output logic [7:0]                         m_byte_index,
    output logic                               m_last,
    output logic                               m_crc_ok,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [slcfr_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [slcfr_pkg::CFG_DATA_W-1:0]   cfg_data
);

    logic [7:0]  sync_first_reg;
    logic [7:0]  sync_second_reg;
    logic [15:0] timeout_ticks_reg;
    logic [7:0]  max_length_reg;

    logic        in_valid_reg;
    logic        in_kind_reg;
    logic [7:0]  in_byte_reg;

    slcfr_pkg::phase_t phase_reg, phase_next;
    logic [7:0]  frame_length_reg, frame_length_next;
    logic [7:0]  position_reg, position_next;
    logic [15:0] crc_reg, crc_next;
    logic [15:0] elapsed_reg, elapsed_next;
    logic        timer_running_reg, timer_running_next;

    logic        out_valid_reg;
    logic [7:0]  out_byte_reg;
    logic [7:0]  out_index_reg;
    logic        out_last_reg;
    logic        out_crc_ok_reg;

    logic        res_valid;
    logic [7:0]  res_index;
    logic        res_last;
    logic        res_crc_ok;

    logic        advance;
    logic        timed_out;
    slcfr_pkg::phase_t phase_eff;
    logic [15:0] crc_upd;

    assign advance   = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    assign m_valid      = out_valid_reg;
    assign m_frame_byte = out_byte_reg;
    assign m_byte_index = out_index_reg;
    assign m_last       = out_last_reg;
    assign m_crc_ok     = out_crc_ok_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sync_first_reg    <= slcfr_pkg::RST_SYNC_FIRST;
            sync_second_reg   <= slcfr_pkg::RST_SYNC_SECOND;
            timeout_ticks_reg <= slcfr_pkg::RST_TIMEOUT_TICKS;
            max_length_reg    <= slcfr_pkg::RST_MAX_LENGTH;
        end else if (cfg_valid && cfg_ready) begin
            unique case (slcfr_pkg::cfg_reg_t'(cfg_index))
                slcfr_pkg::REG_SYNC_FIRST:    sync_first_reg    <= cfg_data[7:0];
                slcfr_pkg::REG_SYNC_SECOND:   sync_second_reg   <= cfg_data[7:0];
                slcfr_pkg::REG_TIMEOUT_TICKS: timeout_ticks_reg <= cfg_data[15:0];
                slcfr_pkg::REG_MAX_LENGTH:    max_length_reg    <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_kind_reg <= s_kind;
            in_byte_reg <= s_byte_value;
        end
    end

    assign timed_out = timer_running_reg && (elapsed_reg > timeout_ticks_reg);
    assign phase_eff = timed_out ? slcfr_pkg::PH_SYNC1 : phase_reg;
    assign crc_upd   = slcfr_pkg::crc16_byte(
                           (phase_eff == slcfr_pkg::PH_LEN) ? slcfr_pkg::CRC_INIT : crc_reg,
                           in_byte_reg);

    always_comb begin
        phase_next         = phase_reg;
        frame_length_next  = frame_length_reg;
        position_next      = position_reg;
        crc_next           = crc_reg;
        elapsed_next       = elapsed_reg;
        timer_running_next = timer_running_reg;
        res_valid          = 1'b0;
        res_index          = 8'd0;
        res_last           = 1'b0;
        res_crc_ok         = 1'b0;

        if (in_kind_reg != slcfr_pkg::KIND_BYTE) begin
            if (timer_running_reg && (elapsed_reg != slcfr_pkg::ELAPSED_MAX)) begin
                elapsed_next = elapsed_reg + 16'd1;
            end
        end else begin
            if (timed_out) begin
                timer_running_next = 1'b0;
            end
            phase_next = phase_eff;
            unique case (phase_eff)
                slcfr_pkg::PH_SYNC1: begin
                    if (in_byte_reg == sync_first_reg) begin
                        phase_next = slcfr_pkg::PH_SYNC2;
                    end
                end
                slcfr_pkg::PH_SYNC2: begin
                    if (in_byte_reg == sync_second_reg) begin
                        phase_next         = slcfr_pkg::PH_LEN;
                        timer_running_next = 1'b1;
                        elapsed_next       = 16'd0;
                    end else begin
                        phase_next = slcfr_pkg::PH_SYNC1;
                    end
                end
                slcfr_pkg::PH_LEN: begin
                    if (in_byte_reg >= slcfr_pkg::MIN_LENGTH
                            && in_byte_reg <= max_length_reg) begin
                        frame_length_next = in_byte_reg;
                        position_next     = 8'd1;
                        crc_next          = crc_upd;
                        phase_next        = slcfr_pkg::PH_DATA;
                        res_valid         = 1'b1;
                    end else begin
                        // timer keeps running after a rejected length
                        phase_next = slcfr_pkg::PH_SYNC1;
                    end
                end
                slcfr_pkg::PH_DATA: begin
                    res_valid     = 1'b1;
                    res_index     = position_reg;
                    res_last      = (position_reg == frame_length_reg);
                    res_crc_ok    = res_last && (crc_upd == 16'd0);
                    crc_next      = crc_upd;
                    position_next = position_reg + 8'd1;
                    if (res_last) begin
                        phase_next         = slcfr_pkg::PH_SYNC1;
                        timer_running_next = 1'b0;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg         <= slcfr_pkg::PH_SYNC1;
            frame_length_reg  <= 8'd0;
            position_reg      <= 8'd0;
            crc_reg           <= slcfr_pkg::CRC_INIT;
            elapsed_reg       <= 16'd0;
            timer_running_reg <= 1'b0;
        end else if (advance) begin
            phase_reg         <= phase_next;
            frame_length_reg  <= frame_length_next;
            position_reg      <= position_next;
            crc_reg           <= crc_next;
            elapsed_reg       <= elapsed_next;
            timer_running_reg <= timer_running_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= res_valid;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && res_valid) begin
            out_byte_reg   <= in_byte_reg;
            out_index_reg  <= res_index;
            out_last_reg   <= res_last;
            out_crc_ok_reg <= res_crc_ok;
        end
    end

endmodule
